// File: rtl/core/ccd_pkg.sv
// ----------------------------------------------------------------------------
// ccd_pkg
// Shared types, constants and helpers for the clock and countdown display.
// ----------------------------------------------------------------------------
package ccd_pkg;

    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_LOAD = 2'd1,
        MODE_SET  = 2'd2
    } mode_t;

    localparam logic [4:0] LAST_HOUR     = 5'd23;
    localparam logic [5:0] LAST_MIN_SEC  = 6'd59;
    localparam logic [6:0] MAX_COUNT_MIN = 7'd99;
    localparam logic [3:0] DASH          = 4'd10;

    typedef logic [3:0] digit_t;

    // Values selected for the display, after the item's update
    typedef struct packed {
        logic [4:0] hi;
        logic [6:0] mi;
        logic [5:0] si;
        logic       done;
        logic       active;
    } disp_t;

    // One result transfer
    typedef struct packed {
        digit_t [7:0] digit;
        logic         done;
        logic         active;
    } result_t;

    // Tens of a value 0..99: multiply by 205/2048, exact over that range
    function automatic digit_t tens_of(input logic [6:0] v);
        logic [14:0] p;
        p = 15'(v) * 15'd205;
        return p[14:11];
    endfunction

    function automatic digit_t units_of(input logic [6:0] v);
        logic [3:0] t;
        logic [6:0] r;
        t = tens_of(v);
        r = v - {t, 3'b000} - {2'b00, t, 1'b0};
        return r[3:0];
    endfunction

endpackage

// File: rtl/core/clock_with_countdown_display_top.sv
// ----------------------------------------------------------------------------
// clock_with_countdown_display_top
// 24-hour clock with a minute/second countdown and an eight-digit display.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | mode, hours, minutes, seconds, flags
//  m_      | out       | m_valid / m_ready  | digit0..digit7, done, active
//
//  One input transfer per cycle while s_ready is high; its result is formed
//  combinationally from the updated state and registered in the result register
//  (or the skid stage when stalled). s_ready is registered: it drops only when
//  the skid stage is full, i.e. after two results are held back by m_ready low.
//  aresetn (synchronous, active low) sets the clock to 00:00:00 running and
//  clears the countdown; no results are pending after reset.
// ----------------------------------------------------------------------------
module clock_with_countdown_display_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [4:0] s_hours_in,
    input  logic [6:0] s_minutes_in,
    input  logic [5:0] s_seconds_in,
    input  logic       s_show_countdown_in,
    input  logic       s_clock_keeps_running,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_digit0,
    output logic [3:0] m_digit1,
    output logic [3:0] m_digit2,
    output logic [3:0] m_digit3,
    output logic [3:0] m_digit4,
    output logic [3:0] m_digit5,
    output logic [3:0] m_digit6,
    output logic [3:0] m_digit7,
    output logic       m_countdown_done,
    output logic       m_countdown_active
);
    import ccd_pkg::*;

    logic    accept;
    disp_t   disp;
    result_t res;
    result_t res_out;

    // state advances on every accepted transfer
    assign accept = s_valid && s_ready;

    ccd_state u_state (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .accept              (accept),
        .mode                (s_mode),
        .hours_in            (s_hours_in),
        .minutes_in          (s_minutes_in),
        .seconds_in          (s_seconds_in),
        .show_countdown_in   (s_show_countdown_in),
        .clock_keeps_running (s_clock_keeps_running),
        .disp                (disp)
    );

    // display digits from the post-update state
    ccd_digits u_digits (
        .disp (disp),
        .res  (res)
    );

    ccd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (res_out)
    );

    assign m_digit0           = res_out.digit[0];
    assign m_digit1           = res_out.digit[1];
    assign m_digit2           = res_out.digit[2];
    assign m_digit3           = res_out.digit[3];
    assign m_digit4           = res_out.digit[4];
    assign m_digit5           = res_out.digit[5];
    assign m_digit6           = res_out.digit[6];
    assign m_digit7           = res_out.digit[7];
    assign m_countdown_done   = res_out.done;
    assign m_countdown_active = res_out.active;

endmodule

// File: rtl/core/ccd_state.sv
// ----------------------------------------------------------------------------
// ccd_state
// Clock and countdown registers, updated once per accepted input transfer.
// ----------------------------------------------------------------------------
module ccd_state (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  logic [1:0]    mode,
    input  logic [4:0]    hours_in,
    input  logic [6:0]    minutes_in,
    input  logic [5:0]    seconds_in,
    input  logic          show_countdown_in,
    input  logic          clock_keeps_running,
    output ccd_pkg::disp_t disp
);
    import ccd_pkg::*;

    logic [4:0] clock_hours_reg,   clock_hours_next;
    logic [5:0] clock_minutes_reg, clock_minutes_next;
    logic [5:0] clock_seconds_reg, clock_seconds_next;
    logic [6:0] count_minutes_reg, count_minutes_next;
    logic [5:0] count_seconds_reg, count_seconds_next;
    logic       count_running_reg, count_running_next;
    logic       clock_running_reg, clock_running_next;
    logic       done_flag_reg,     done_flag_next;
    logic       show_countdown_reg, show_countdown_next;

    always_comb begin
        clock_hours_next    = clock_hours_reg;
        clock_minutes_next  = clock_minutes_reg;
        clock_seconds_next  = clock_seconds_reg;
        count_minutes_next  = count_minutes_reg;
        count_seconds_next  = count_seconds_reg;
        count_running_next  = count_running_reg;
        clock_running_next  = clock_running_reg;
        done_flag_next      = done_flag_reg;
        show_countdown_next = show_countdown_reg;
        if (accept) begin
            case (mode_t'(mode))
                MODE_TICK: begin
                    if (clock_running_reg) begin
                        if (clock_seconds_reg >= LAST_MIN_SEC) begin
                            clock_seconds_next = '0;
                            if (clock_minutes_reg >= LAST_MIN_SEC) begin
                                clock_minutes_next = '0;
                                if (clock_hours_reg >= LAST_HOUR) begin
                                    clock_hours_next = '0;
                                end else begin
                                    clock_hours_next = clock_hours_reg + 5'd1;
                                end
                            end else begin
                                clock_minutes_next = clock_minutes_reg + 6'd1;
                            end
                        end else begin
                            clock_seconds_next = clock_seconds_reg + 6'd1;
                        end
                    end
                    if (count_running_reg) begin
                        if (count_seconds_reg != '0) begin
                            count_seconds_next = count_seconds_reg - 6'd1;
                        end else if (count_minutes_reg != '0) begin
                            count_minutes_next = count_minutes_reg - 7'd1;
                            count_seconds_next = LAST_MIN_SEC;
                        end else begin
                            // finished: stop, restart clock, hide countdown
                            count_running_next  = 1'b0;
                            clock_running_next  = 1'b1;
                            done_flag_next      = 1'b1;
                            show_countdown_next = 1'b0;
                        end
                    end
                end
                MODE_LOAD: begin
                    count_minutes_next  = (minutes_in > MAX_COUNT_MIN) ? MAX_COUNT_MIN
                                                                       : minutes_in;
                    count_seconds_next  = (seconds_in > LAST_MIN_SEC) ? LAST_MIN_SEC
                                                                      : seconds_in;
                    count_running_next  = 1'b1;
                    clock_running_next  = clock_keeps_running;
                    show_countdown_next = show_countdown_in;
                    done_flag_next      = 1'b0;
                end
                MODE_SET: begin
                    clock_hours_next   = (hours_in > LAST_HOUR) ? LAST_HOUR : hours_in;
                    clock_minutes_next = (minutes_in > 7'(LAST_MIN_SEC)) ? LAST_MIN_SEC
                                                                         : minutes_in[5:0];
                    clock_seconds_next = (seconds_in > LAST_MIN_SEC) ? LAST_MIN_SEC
                                                                     : seconds_in;
                end
                default: begin
                    // unused mode: no change
                end
            endcase
        end
    end

    always_comb begin
        if (show_countdown_next && (count_minutes_next != '0 || count_seconds_next != '0)) begin
            disp.hi = '0;
            disp.mi = count_minutes_next;
            disp.si = count_seconds_next;
        end else begin
            disp.hi = clock_hours_next;
            disp.mi = {1'b0, clock_minutes_next};
            disp.si = clock_seconds_next;
        end
        disp.done   = done_flag_next;
        disp.active = count_running_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hours_reg    <= '0;
            clock_minutes_reg  <= '0;
            clock_seconds_reg  <= '0;
            count_minutes_reg  <= '0;
            count_seconds_reg  <= '0;
            count_running_reg  <= 1'b0;
            clock_running_reg  <= 1'b1;
            done_flag_reg      <= 1'b0;
            show_countdown_reg <= 1'b0;
        end else begin
            clock_hours_reg    <= clock_hours_next;
            clock_minutes_reg  <= clock_minutes_next;
            clock_seconds_reg  <= clock_seconds_next;
            count_minutes_reg  <= count_minutes_next;
            count_seconds_reg  <= count_seconds_next;
            count_running_reg  <= count_running_next;
            clock_running_reg  <= clock_running_next;
            done_flag_reg      <= done_flag_next;
            show_countdown_reg <= show_countdown_next;
        end
    end

endmodule

// File: rtl/core/ccd_digits.sv
// ----------------------------------------------------------------------------
// ccd_digits
// Splits the selected hours, minutes and seconds into display digits.
// ----------------------------------------------------------------------------
module ccd_digits (
    input  ccd_pkg::disp_t   disp,
    output ccd_pkg::result_t res
);
    import ccd_pkg::*;

    always_comb begin
        res.digit[0] = tens_of({2'b00, disp.hi});
        res.digit[1] = units_of({2'b00, disp.hi});
        res.digit[2] = DASH;
        res.digit[3] = tens_of(disp.mi);
        res.digit[4] = units_of(disp.mi);
        res.digit[5] = DASH;
        res.digit[6] = tens_of({1'b0, disp.si});
        res.digit[7] = units_of({1'b0, disp.si});
        res.done     = disp.done;
        res.active   = disp.active;
    end

endmodule

// File: rtl/core/ccd_out_buf.sv
// ----------------------------------------------------------------------------
// ccd_out_buf
// Result register with a skid stage; ready towards the input is registered.
// ----------------------------------------------------------------------------
module ccd_out_buf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  ccd_pkg::result_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output ccd_pkg::result_t out_data
);
    import ccd_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        if (skid_valid_reg && out_ready) begin
            // skid drains into the result register
            out_next        = skid_reg;
            out_valid_next  = 1'b1;
            skid_valid_next = 1'b0;
        end
        if (in_valid && in_ready) begin
            if (out_valid_reg && !out_ready) begin
                skid_next       = in_data;
                skid_valid_next = 1'b1;
            end else begin
                out_next       = in_data;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

`ifndef NO_ASSERTIONS
    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds data while result register is empty");

    a_stall_fills_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready && out_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("transfer during stall not caught by skid stage");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && out_ready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid stage did not drain into result register");
`endif

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the clock and countdown display. A driver feeds
// ticks, countdown loads and clock sets from a queue; a built-in model of the
// clock and countdown predicts the eight display digits and the status bits,
// and a monitor checks every result transfer against the oldest prediction.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import ccd_pkg::*;

    // The two-bit mode field has one code that the block ignores
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int MAX_WAIT     = 17;      // longest gap or stall, in cycles
    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_EVERY  = 250;     // sender waits for an empty pipe
    localparam int PRINT_CAP    = 100;     // mismatch lines shown at most

    // One input item, plus a flag that holds it back until all results are in
    typedef struct {
        logic [1:0] mode;
        logic [4:0] hours;
        logic [6:0] minutes;
        logic [5:0] seconds;
        logic       show;
        logic       keep;
        bit         drain_first;
    } clock_cmd_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;

    logic       s_valid               = 1'b0;
    logic       s_ready;
    logic [1:0] s_mode                = 2'd0;
    logic [4:0] s_hours_in            = 5'd0;
    logic [6:0] s_minutes_in          = 7'd0;
    logic [5:0] s_seconds_in          = 6'd0;
    logic       s_show_countdown_in   = 1'b0;
    logic       s_clock_keeps_running = 1'b0;

    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [3:0] m_digit0, m_digit1, m_digit2, m_digit3;
    logic [3:0] m_digit4, m_digit5, m_digit6, m_digit7;
    logic       m_countdown_done;
    logic       m_countdown_active;

    always #6 aclk = ~aclk;

    clock_with_countdown_display_top i_dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_mode                (s_mode),
        .s_hours_in            (s_hours_in),
        .s_minutes_in          (s_minutes_in),
        .s_seconds_in          (s_seconds_in),
        .s_show_countdown_in   (s_show_countdown_in),
        .s_clock_keeps_running (s_clock_keeps_running),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_digit0              (m_digit0),
        .m_digit1              (m_digit1),
        .m_digit2              (m_digit2),
        .m_digit3              (m_digit3),
        .m_digit4              (m_digit4),
        .m_digit5              (m_digit5),
        .m_digit6              (m_digit6),
        .m_digit7              (m_digit7),
        .m_countdown_done      (m_countdown_done),
        .m_countdown_active    (m_countdown_active)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    clock_cmd_t cmd_queue[$];        // items still to be sent
    result_t    display_queue[$];    // predicted displays, oldest first
    clock_cmd_t cur_cmd;

    int  n_total     = 0;
    int  n_accepted  = 0;
    int  n_checked   = 0;
    int  n_errors    = 0;
    int  n_ticks     = 0;
    int  n_loads     = 0;
    int  n_sets      = 0;
    int  n_unused    = 0;
    int  n_finished  = 0;
    int  src_gap     = 0;
    int  snk_stall   = 0;
    bit  src_calm    = 1'b0;
    bit  snk_calm    = 1'b0;

    // Model of the block's state
    logic [4:0] clk_h;
    logic [5:0] clk_m;
    logic [5:0] clk_s;
    logic [6:0] cnt_m;
    logic [5:0] cnt_s;
    logic       cnt_run;
    logic       clk_run;
    logic       done_q;
    logic       show_cnt;

    // ------------------------------------------------------------------------
    // Predictor: applies one item to the model state and returns the display
    // as it stands after the update.
    // ------------------------------------------------------------------------
    function automatic result_t advance_and_display(input clock_cmd_t cmd);
        result_t r;
        int      hi;
        int      mi;
        int      si;
        case (cmd.mode)
            MODE_TICK: begin
                n_ticks++;
                // clock first; a clock restarted by a finishing countdown
                // only moves from the following tick
                if (clk_run) begin
                    if (clk_s == LAST_MIN_SEC) begin
                        clk_s = '0;
                        if (clk_m == LAST_MIN_SEC) begin
                            clk_m = '0;
                            clk_h = (clk_h == LAST_HOUR) ? 5'd0 : clk_h + 5'd1;
                        end else begin
                            clk_m = clk_m + 6'd1;
                        end
                    end else begin
                        clk_s = clk_s + 6'd1;
                    end
                end
                if (cnt_run) begin
                    if (cnt_s != 0) begin
                        cnt_s = cnt_s - 6'd1;
                    end else if (cnt_m != 0) begin
                        cnt_m = cnt_m - 7'd1;
                        cnt_s = LAST_MIN_SEC;
                    end else begin
                        // stepped while already at zero: countdown finishes
                        cnt_run  = 1'b0;
                        clk_run  = 1'b1;
                        done_q   = 1'b1;
                        show_cnt = 1'b0;
                        n_finished++;
                    end
                end
            end
            MODE_LOAD: begin
                n_loads++;
                cnt_m    = (cmd.minutes > MAX_COUNT_MIN) ? MAX_COUNT_MIN : cmd.minutes;
                cnt_s    = (cmd.seconds > LAST_MIN_SEC) ? LAST_MIN_SEC : cmd.seconds;
                cnt_run  = 1'b1;
                clk_run  = cmd.keep;
                show_cnt = cmd.show;
                done_q   = 1'b0;
            end
            MODE_SET: begin
                n_sets++;
                clk_h = (cmd.hours > LAST_HOUR) ? LAST_HOUR : cmd.hours;
                clk_m = (cmd.minutes > 7'(LAST_MIN_SEC)) ? LAST_MIN_SEC
                                                         : cmd.minutes[5:0];
                clk_s = (cmd.seconds > LAST_MIN_SEC) ? LAST_MIN_SEC : cmd.seconds;
            end
            default: begin
                n_unused++;
            end
        endcase

        // countdown on show only while it is not at zero
        if (show_cnt && (cnt_m != 0 || cnt_s != 0)) begin
            hi = 0;
            mi = cnt_m;
            si = cnt_s;
        end else begin
            hi = clk_h;
            mi = clk_m;
            si = clk_s;
        end
        r.digit[0] = digit_t'(hi / 10);
        r.digit[1] = digit_t'(hi % 10);
        r.digit[2] = DASH;
        r.digit[3] = digit_t'(mi / 10);
        r.digit[4] = digit_t'(mi % 10);
        r.digit[5] = DASH;
        r.digit[6] = digit_t'(si / 10);
        r.digit[7] = digit_t'(si % 10);
        r.done     = done_q;
        r.active   = cnt_run;
        return r;
    endfunction

    // Idle/stall length for one transfer; now and then switch between a
    // calm stretch (no idling at all) and a busy one
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic clock_cmd_t make_cmd(input logic [1:0] mode,
                                            input int h, input int m, input int s,
                                            input bit show, input bit keep);
        clock_cmd_t c;
        c.mode        = mode;
        c.hours       = 5'(h);
        c.minutes     = 7'(m);
        c.seconds     = 6'(s);
        c.show        = show;
        c.keep        = keep;
        c.drain_first = 1'b0;
        return c;
    endfunction

    // Mostly ticks, with short countdowns so that many of them finish, clock
    // sets near midnight, raw full-width values and the odd unused mode
    function automatic clock_cmd_t random_cmd(input int idx);
        clock_cmd_t c;
        int         r;
        r             = $urandom_range(0, 99);
        c.hours       = 5'($urandom_range(0, 31));
        c.minutes     = 7'($urandom_range(0, 127));
        c.seconds     = 6'($urandom_range(0, 63));
        c.show        = 1'($urandom_range(0, 1));
        c.keep        = 1'($urandom_range(0, 1));
        c.drain_first = (idx % DRAIN_EVERY == 0);
        if (r < 62) begin
            c.mode = MODE_TICK;
        end else if (r < 74) begin
            c.mode = MODE_LOAD;
            if ($urandom_range(0, 7) != 0) begin
                c.minutes = 7'($urandom_range(0, 1));
                c.seconds = 6'($urandom_range(0, 12));
            end
        end else if (r < 94) begin
            c.mode = MODE_SET;
            case ($urandom_range(0, 3))
                0: ;    // raw values, clamping exercised
                1: begin
                    c.hours   = 5'($urandom_range(22, 23));
                    c.minutes = 7'($urandom_range(58, 59));
                    c.seconds = 6'($urandom_range(55, 59));
                end
                default: begin
                    c.hours   = 5'($urandom_range(0, 23));
                    c.minutes = 7'($urandom_range(0, 59));
                    c.seconds = 6'($urandom_range(0, 59));
                end
            endcase
        end else begin
            c.mode = MODE_UNUSED;
        end
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        if (n_errors < PRINT_CAP)
            $display("testbench: mismatch: %s", msg);
        n_errors++;
    endtask

    // Compare one result transfer with the oldest prediction
    task automatic check_display();
        result_t want;
        digit_t  got [8];
        got = '{m_digit0, m_digit1, m_digit2, m_digit3,
                m_digit4, m_digit5, m_digit6, m_digit7};
        n_checked++;
        if (display_queue.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected",
                                      n_checked));
        end else begin
            want = display_queue.pop_front();
            for (int i = 0; i < 8; i++) begin
                if (got[i] !== want.digit[i])
                    report_mismatch($sformatf("result %0d: digit%0d is %0d, expected %0d",
                                              n_checked, i, got[i], want.digit[i]));
            end
            if (m_countdown_done !== want.done)
                report_mismatch($sformatf("result %0d: countdown_done is %b, expected %b",
                                          n_checked, m_countdown_done, want.done));
            if (m_countdown_active !== want.active)
                report_mismatch($sformatf("result %0d: countdown_active is %b, expected %b",
                                          n_checked, m_countdown_active, want.active));
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: one item per input transfer. Valid stays up with a steady
    // payload until the transfer; between items a random gap is drawn. An
    // item flagged drain_first waits until every predicted result is in.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                display_queue.push_back(advance_and_display(cur_cmd));
                n_accepted++;
                src_gap = draw_wait(src_calm);
            end
            if (s_valid && !s_ready) begin
                // transfer still pending: hold valid and payload
            end else if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (cmd_queue.size() != 0 &&
                         !(cmd_queue[0].drain_first && display_queue.size() != 0)) begin
                cur_cmd = cmd_queue.pop_front();
                s_mode                <= cur_cmd.mode;
                s_hours_in            <= cur_cmd.hours;
                s_minutes_in          <= cur_cmd.minutes;
                s_seconds_in          <= cur_cmd.seconds;
                s_show_countdown_in   <= cur_cmd.show;
                s_clock_keeps_running <= cur_cmd.keep;
                s_valid               <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each result transfer, then holds ready low for a
    // randomly drawn number of cycles
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                check_display();
                snk_stall = draw_wait(snk_calm);
            end else if (snk_stall > 0) begin
                snk_stall--;
            end
            m_ready <= (snk_stall == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        // model state after reset: clock 00:00:00 running, countdown idle
        clk_h    = '0;
        clk_m    = '0;
        clk_s    = '0;
        cnt_m    = '0;
        cnt_s    = '0;
        cnt_run  = 1'b0;
        clk_run  = 1'b1;
        done_q   = 1'b0;
        show_cnt = 1'b0;

        // directed part
        cmd_queue.push_back(make_cmd(MODE_TICK,    31, 127, 63, 1, 1));  // from reset
        cmd_queue.push_back(make_cmd(MODE_UNUSED,  31, 127, 63, 1, 1));  // ignored
        cmd_queue.push_back(make_cmd(MODE_SET,     31, 127, 63, 0, 0));  // clamps to 23:59:59
        cmd_queue.push_back(make_cmd(MODE_TICK,     0,   0,  0, 0, 0));  // midnight wrap
        cmd_queue.push_back(make_cmd(MODE_SET,     23,  59, 58, 0, 0));
        cmd_queue.push_back(make_cmd(MODE_LOAD,    31, 127, 63, 1, 0));  // clamps to 99:59
        cmd_queue.push_back(make_cmd(MODE_TICK,     0,   0,  0, 0, 0));  // clock held
        cmd_queue.push_back(make_cmd(MODE_LOAD,     0,   0,  0, 1, 0));  // zero load
        cmd_queue.push_back(make_cmd(MODE_TICK,     0,   0,  0, 0, 0));  // finishes, done set
        cmd_queue.push_back(make_cmd(MODE_TICK,     0,   0,  0, 0, 0));  // clock moves again
        cmd_queue.push_back(make_cmd(MODE_LOAD,     0,   0,  2, 1, 1));  // clears done
        cmd_queue.push_back(make_cmd(MODE_TICK,     0,   0,  0, 0, 0));
        cmd_queue.push_back(make_cmd(MODE_TICK,     0,   0,  0, 0, 0));  // at zero, clock shown
        cmd_queue.push_back(make_cmd(MODE_TICK,     0,   0,  0, 0, 0));  // finishes
        cmd_queue.push_back(make_cmd(MODE_LOAD,     0,   1,  0, 0, 1));  // hidden countdown
        cmd_queue.push_back(make_cmd(MODE_TICK,     0,   0,  0, 0, 0));  // minute borrow
        cmd_queue.push_back(make_cmd(MODE_SET,      0,   0,  0, 1, 1));  // set mid-countdown
        cmd_queue.push_back(make_cmd(MODE_LOAD,     0,  60,  1, 1, 0));
        cmd_queue.push_back(make_cmd(MODE_SET,     12,  34, 56, 0, 0));  // shown count wins
        cmd_queue.push_back(make_cmd(MODE_TICK,     0,   0,  0, 0, 0));
        cmd_queue.push_back(make_cmd(MODE_UNUSED,   0,   0,  0, 0, 0));
        cmd_queue.push_back(make_cmd(MODE_SET,     24,  60, 60, 0, 0));  // just out of range
        cmd_queue.push_back(make_cmd(MODE_LOAD,     0, 100, 60, 1, 1));  // just out of range

        // random part
        for (int i = 0; i < RANDOM_ITEMS; i++)
            cmd_queue.push_back(random_cmd(i));
        n_total = cmd_queue.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // every item sent, every prediction checked, then a short quiet spell
        // to catch stray results
        while (n_accepted != n_total) @(posedge aclk);
        while (display_queue.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("testbench: %0d items: %0d ticks, %0d loads, %0d clock sets, %0d unused",
                 n_accepted, n_ticks, n_loads, n_sets, n_unused);
        $display("testbench: %0d results checked, %0d countdowns ran out, %0d mismatches",
                 n_checked, n_finished, n_errors);
        if (n_errors == 0 && display_queue.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // Watchdog, well beyond the slowest legal run
    initial begin
        #(12 * 400000);
        $display("testbench: FAIL");
        $finish;
    end

endmodule
